>>> src/pwst_pkg.sv
// Shared types and constants for the pulse-width serial transmitter.
// Used by pwst_core, pulse_width_serial_transmitter and the testbench; no dependencies.

package pwst_pkg;

	// Width of one timing register and of the phase timer
	localparam int unsigned TICK_W     = 16;
	// Width of the register index on the configuration channel
	localparam int unsigned CFG_IDX_W  = 8;
	// Width of the data byte carried on the input stream
	localparam int unsigned BYTE_W     = 8;
	// Default word length of a frame
	localparam int unsigned DATA_BITS_DEF = 8;

	// Reset values of the timing registers
	localparam logic [TICK_W-1:0] SPACE_RST = 16'd100;
	localparam logic [TICK_W-1:0] ZERO_RST  = 16'd50;
	localparam logic [TICK_W-1:0] ONE_RST   = 16'd150;
	localparam logic [TICK_W-1:0] STOP_RST  = 16'd200;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SPACE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO  = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ONE   = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STOP  = 8'd3;

	// Input item kinds (carried on tuser)
	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_SEND = 1'b1;

	// Timing register set
	typedef struct packed {
		logic [TICK_W-1:0] space_ticks;
		logic [TICK_W-1:0] zero_ticks;
		logic [TICK_W-1:0] one_ticks;
		logic [TICK_W-1:0] stop_ticks;
	} pwst_cfg_t;

	// One result item
	typedef struct packed {
		logic frame_done;
		logic accepted;
		logic busy_res;
		logic line_low;
	} pwst_res_t;

endpackage

>>> src/pwst_core.sv
// Frame sequencer of the pulse-width serial transmitter.
// Holds phase, timer, shift register and bit count; depends on pwst_pkg.

module pwst_core
	import pwst_pkg::*;
#(
	parameter int unsigned DATA_BITS = DATA_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,   // input transaction taken this cycle
	input  logic              cmd,
	input  logic [BYTE_W-1:0] data,
	input  pwst_cfg_t         cfg,
	output pwst_res_t         res        // result of the item presented now
);

	localparam int unsigned BL_W = $clog2(DATA_BITS + 1);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_START_LOW,
		PH_START_HIGH,
		PH_BIT_LOW,
		PH_BIT_HIGH,
		PH_STOP
	} phase_t;

	phase_t                 phase_q, phase_n;
	logic [TICK_W-1:0]      timer_q, timer_n, timer_dec;
	logic [DATA_BITS-1:0]   shift_q, shift_n;
	logic [BL_W-1:0]        bits_q, bits_n;
	logic                   line_q, line_n;
	logic                   accepted, done;
	logic [DATA_BITS+BYTE_W-1:0] data_ext;

	// A zero-length phase still lasts one tick
	function automatic logic [TICK_W-1:0] load_ticks(input logic [TICK_W-1:0] t);
		load_ticks = (t == '0) ? TICK_W'(1) : t;
	endfunction

	assign data_ext  = {{DATA_BITS{1'b0}}, data};
	assign timer_dec = timer_q - TICK_W'(timer_q != '0);

	// Next state for one item
	always_comb begin
		phase_n  = phase_q;
		timer_n  = timer_q;
		shift_n  = shift_q;
		bits_n   = bits_q;
		line_n   = line_q;
		accepted = 1'b0;
		done     = 1'b0;
		if (cmd == CMD_SEND) begin
			if (phase_q == PH_IDLE) begin
				shift_n  = data_ext[DATA_BITS-1:0];
				bits_n   = BL_W'(DATA_BITS);
				phase_n  = PH_START_LOW;
				timer_n  = load_ticks(cfg.space_ticks);
				line_n   = 1'b1;
				accepted = 1'b1;
			end
		end else if (phase_q != PH_IDLE) begin
			timer_n = timer_dec;
			if (timer_dec == '0) begin
				unique case (phase_q)
					PH_START_LOW: begin
						phase_n = PH_START_HIGH;
						timer_n = load_ticks(cfg.space_ticks);
						line_n  = 1'b0;
					end
					PH_BIT_LOW: begin
						phase_n = PH_BIT_HIGH;
						timer_n = load_ticks(cfg.space_ticks);
						line_n  = 1'b0;
					end
					PH_START_HIGH, PH_BIT_HIGH: begin
						if (phase_q == PH_BIT_HIGH && bits_q == '0) begin
							phase_n = PH_STOP;
							timer_n = load_ticks(cfg.stop_ticks);
							line_n  = 1'b0;
						end else begin
							// next bit, MSB first
							shift_n = shift_q << 1;
							if (bits_q != '0)
								bits_n = bits_q - BL_W'(1);
							phase_n = PH_BIT_LOW;
							timer_n = load_ticks(shift_q[DATA_BITS-1] ?
								cfg.one_ticks : cfg.zero_ticks);
							line_n  = 1'b1;
						end
					end
					default: begin
						// end of stop period
						phase_n = PH_IDLE;
						timer_n = '0;
						line_n  = 1'b0;
						done    = 1'b1;
					end
				endcase
			end
		end
	end

	assign res.line_low   = line_n;
	assign res.busy_res   = (phase_n != PH_IDLE);
	assign res.accepted   = accepted;
	assign res.frame_done = done;

	// State and line level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			timer_q <= '0;
			shift_q <= '0;
			bits_q  <= '0;
			line_q  <= 1'b0;
		end else if (step_en) begin
			phase_q <= phase_n;
			timer_q <= timer_n;
			shift_q <= shift_n;
			bits_q  <= bits_n;
			line_q  <= line_n;
		end
	end

endmodule

>>> src/pulse_width_serial_transmitter.sv
// Pulse-width serial transmitter: top level with timing registers and
// output skid stage. Depends on pwst_pkg and pwst_core.
//
// Usage:
//   s_axis: one transaction per item. tuser is the kind (0 = time tick,
//     1 = send the byte in tdata). A send while a frame runs is ignored
//     and answered with accepted = 0; it does not advance time.
//   m_axis: exactly one result per input item, in order. tdata bits from
//     bit 0: line_low, busy_res, accepted, frame_done.
//   cfg: register writes (0 space, 1 zero, 2 one, 3 stop ticks); always
//     ready, other indexes ignored. A new value applies at the next phase.
// Timing:
//   One item per clock while s_axis_tready is high. All per-item work
//   is one pass of the sequencer logic from the state registers to the
//   result register (or the skid register while the result is held).
// Reset: registers return to 100/50/150/200, the line is released and
//   the block is idle with no results pending.
// Stall: a two-entry output stage (result register plus skid register)
//   holds results; s_axis_tready drops only when both are full.

module pulse_width_serial_transmitter
	import pwst_pkg::*;
#(
	parameter int unsigned DATA_BITS = DATA_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// input stream
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [BYTE_W-1:0]    s_axis_tdata,   // [7:0] data
	input  logic                 s_axis_tuser,   // [0] cmd
	// result stream
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [7:0]           m_axis_tdata,   // [0] line_low, [1] busy_res,
	                                             // [2] accepted, [3] frame_done
	// configuration writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TICK_W-1:0]    cfg_data
);

	pwst_cfg_t cfg_q;
	pwst_res_t res;
	pwst_res_t out_q, skid_q;
	logic      out_valid_q, skid_valid_q;
	logic      in_acc, out_pop;

	assign cfg_ready = 1'b1;

	// Timing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.space_ticks <= SPACE_RST;
			cfg_q.zero_ticks  <= ZERO_RST;
			cfg_q.one_ticks   <= ONE_RST;
			cfg_q.stop_ticks  <= STOP_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SPACE: cfg_q.space_ticks <= cfg_data;
				REG_ZERO:  cfg_q.zero_ticks  <= cfg_data;
				REG_ONE:   cfg_q.one_ticks   <= cfg_data;
				REG_STOP:  cfg_q.stop_ticks  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign s_axis_tready = !skid_valid_q;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_pop       = out_valid_q && m_axis_tready;

	pwst_core #(
		.DATA_BITS(DATA_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step_en(in_acc),
		.cmd    (s_axis_tuser),
		.data   (s_axis_tdata),
		.cfg    (cfg_q),
		.res    (res)
	);

	// Result register with skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
			out_q        <= '0;
			skid_q       <= '0;
		end else if (out_pop || !out_valid_q) begin
			if (skid_valid_q) begin
				out_q        <= skid_q;
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_q       <= res;
				out_valid_q <= in_acc;
			end
		end else if (in_acc) begin
			skid_q       <= res;
			skid_valid_q <= 1'b1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0000, out_q.frame_done, out_q.accepted,
		out_q.busy_res, out_q.line_low};

`ifndef SYNTH
	// A skid entry only exists behind a held result
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry without result");

	// A started frame is in progress
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.accepted) |-> (out_q.busy_res && out_q.line_low))
		else $error("accepted send without busy low line");

	// Frame end leaves the block idle with the line released
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.frame_done) |-> (!out_q.busy_res && !out_q.line_low))
		else $error("frame end while busy");

	// The line is never driven while idle
	a_idle_released: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.busy_res) |-> !out_q.line_low)
		else $error("line low while idle");
`endif

endmodule

>>> dv/pulse_width_serial_transmitter_test.sv
// Self-checking testbench for pulse_width_serial_transmitter: streams tick and send
// transactions, predicts each result from a local line model and compares it field by field.
// Depends on pwst_pkg and the transmitter RTL only.
`timescale 1ns / 100ps

module pulse_width_serial_transmitter_test;
	import pwst_pkg::*;

	localparam int CLK_HALF     = 10;        // 20 ns period
	localparam int RST_CYCLES   = 7;
	localparam int RAND_ITEMS   = 150;       // random transactions that touch a frame
	localparam int HOLD_CYCLES  = 300;       // long receiver hold-off
	localparam int TAIL_CYCLES  = 20;
	localparam int LIMIT_CYCLES = 3_000_000;

	localparam logic [CFG_IDX_W-1:0] REG_NONE = 8'hFF;   // unmapped register index
	localparam logic [TICK_W-1:0]    TICK_MAX = 16'hFFFF;

	// Line phases of the local model
	typedef enum logic [2:0] {
		ST_IDLE, ST_LEAD_LOW, ST_LEAD_HIGH, ST_MARK, ST_SPACE, ST_TAIL
	} line_phase_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [BYTE_W-1:0]    s_axis_tdata = '0;   // [7:0] data
	logic                 s_axis_tuser = 1'b0; // [0] cmd
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [7:0]           m_axis_tdata;        // [0] line_low, [1] busy_res,
	                                           // [2] accepted, [3] frame_done
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [TICK_W-1:0]    cfg_data = '0;

	pulse_width_serial_transmitter u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Line model state and its copy of the timing registers
	pwst_cfg_t tcfg = '{space_ticks: SPACE_RST, zero_ticks: ZERO_RST,
		one_ticks: ONE_RST, stop_ticks: STOP_RST};
	line_phase_t       lp_phase = ST_IDLE;
	logic [TICK_W-1:0] lp_timer = '0;
	logic [BYTE_W-1:0] lp_shift = '0;
	logic [3:0]        lp_bits_left = '0;
	logic              lp_low = 1'b0;

	pwst_res_t line_results[$];   // predicted results, oldest first
	int        frame_items = 0;   // transactions that started a frame or were taken while one ran
	int        mismatches = 0;

	// Idling control: calm flags switch random gaps off on either side
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;
	int hold_requests = 0;
	int hold_seen = 0;
	int hold_left = 0;

	// A phase loaded with zero still lasts one tick
	function automatic void enter_phase(line_phase_t ph, logic [TICK_W-1:0] ticks, logic low);
		lp_phase = ph;
		lp_timer = (ticks == '0) ? TICK_W'(1) : ticks;
		lp_low   = low;
	endfunction

	// Shift out the next bit, MSB first, and start its low part
	function automatic void next_bit();
		logic b;
		b = lp_shift[BYTE_W-1];
		lp_shift = lp_shift << 1;
		if (lp_bits_left != 0)
			lp_bits_left--;
		enter_phase(ST_MARK, b ? tcfg.one_ticks : tcfg.zero_ticks, 1'b1);
	endfunction

	// One input transaction through the line model
	function automatic pwst_res_t step_line_model(logic cmd, logic [BYTE_W-1:0] d);
		pwst_res_t r;
		r = '0;
		if (cmd == CMD_SEND) begin
			// a send while busy is dropped and does not advance time
			if (lp_phase == ST_IDLE) begin
				lp_shift = d;
				lp_bits_left = 4'(DATA_BITS_DEF);
				enter_phase(ST_LEAD_LOW, tcfg.space_ticks, 1'b1);
				r.accepted = 1'b1;
			end
		end else if (lp_phase != ST_IDLE) begin
			if (lp_timer != 0)
				lp_timer--;
			if (lp_timer == 0) begin
				case (lp_phase)
					ST_LEAD_LOW:  enter_phase(ST_LEAD_HIGH, tcfg.space_ticks, 1'b0);
					ST_LEAD_HIGH: next_bit();
					ST_MARK:      enter_phase(ST_SPACE, tcfg.space_ticks, 1'b0);
					ST_SPACE: begin
						if (lp_bits_left == 0)
							enter_phase(ST_TAIL, tcfg.stop_ticks, 1'b0);
						else
							next_bit();
					end
					default: begin
						lp_phase = ST_IDLE;
						lp_timer = '0;
						lp_low = 1'b0;
						r.frame_done = 1'b1;
					end
				endcase
			end
		end
		r.line_low = lp_low;
		r.busy_res = (lp_phase != ST_IDLE);
		return r;
	endfunction

	task automatic report_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Receiver: random stalls, calm stretches and a counted long hold-off
	always @(posedge clk) begin
		if (hold_seen != hold_requests) begin
			hold_seen <= hold_requests;
			hold_left <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= rx_calm || ($urandom_range(99) >= 24);
		end
	end

	// Register writes, then input transactions, then result checks
	always @(posedge clk) begin : line_monitor
		pwst_res_t want;
		pwst_res_t got;
		logic      was_busy;
		if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SPACE: tcfg.space_ticks = cfg_data;
				REG_ZERO:  tcfg.zero_ticks  = cfg_data;
				REG_ONE:   tcfg.one_ticks   = cfg_data;
				REG_STOP:  tcfg.stop_ticks  = cfg_data;
				default: ;
			endcase
		end
		if (s_axis_tvalid && s_axis_tready) begin
			was_busy = (lp_phase != ST_IDLE);
			want = step_line_model(s_axis_tuser, s_axis_tdata);
			if (was_busy || want.accepted)
				frame_items++;
			line_results.push_back(want);
		end
		if (m_axis_tvalid && m_axis_tready) begin
			got = pwst_res_t'(m_axis_tdata[3:0]);
			if (line_results.size() == 0) begin
				$error("result 0x%02h with no transaction pending", m_axis_tdata);
				mismatches++;
			end else begin
				want = line_results.pop_front();
				report_field("line_low", 8'(want.line_low), 8'(got.line_low));
				report_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
				report_field("accepted", 8'(want.accepted), 8'(got.accepted));
				report_field("frame_done", 8'(want.frame_done), 8'(got.frame_done));
				report_field("pad", 8'd0, {4'd0, m_axis_tdata[7:4]});
			end
		end
	end

	// One input transaction; valid stays high for a following back-to-back one
	task automatic send_item(logic cmd, logic [BYTE_W-1:0] d);
		while (!tx_calm && $urandom_range(99) < 24) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= d;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic send_tick();
		send_item(CMD_TICK, 8'($urandom));
	endtask

	// Sender pause until every predicted result has been seen
	task automatic wait_drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (line_results.size() != 0);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [TICK_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// All four timing registers, optionally followed by a write to an unmapped index
	task automatic program_timing(logic [TICK_W-1:0] sp, logic [TICK_W-1:0] zr,
		logic [TICK_W-1:0] on, logic [TICK_W-1:0] st, logic stray);
		wait_drain();
		cfg_write(REG_SPACE, sp);
		cfg_write(REG_ZERO, zr);
		cfg_write(REG_ONE, on);
		cfg_write(REG_STOP, st);
		if (stray)
			cfg_write(REG_NONE, 16'($urandom));
		cfg_valid <= 1'b0;
	endtask

	task automatic finish_frame();
		do send_tick(); while (lp_phase != ST_IDLE);
	endtask

	task automatic run_frame(logic [BYTE_W-1:0] d, int busy_sends);
		send_item(CMD_SEND, d);
		repeat (busy_sends) send_item(CMD_SEND, 8'($urandom));
		finish_frame();
	endtask

	// Mostly short phases, some zero, a few longer
	function automatic logic [TICK_W-1:0] rand_tick();
		int p;
		p = $urandom_range(99);
		if (p < 12)
			return '0;
		if (p < 85)
			return TICK_W'($urandom_range(4, 1));
		return TICK_W'($urandom_range(12, 5));
	endfunction

	// Ticks while idle, then a frame whose start low phase runs at the reset
	// space time; the rest of the frame runs at short timing
	task automatic test_idle_and_defaults();
		send_item(CMD_TICK, 8'hFF);
		send_item(CMD_TICK, 8'h00);
		send_item(CMD_SEND, 8'hA5);
		repeat (int'(SPACE_RST) - 1) send_tick();
		program_timing(16'd1, 16'd1, 16'd2, 16'd1, 1'b0);
		finish_frame();
	endtask

	// Shortest timing, all-zero and all-one bytes, zero registers, sends while busy
	task automatic test_min_timing();
		program_timing(16'd1, 16'd1, 16'd1, 16'd1, 1'b0);
		run_frame(8'h00, 0);
		run_frame(8'hFF, 0);
		program_timing(16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
		run_frame(8'h5A, 2);
	endtask

	// New timing written in the middle of a frame applies from the next phase
	task automatic test_mid_frame_change();
		program_timing(16'd2, 16'd2, 16'd3, 16'd2, 1'b0);
		send_item(CMD_SEND, 8'hC3);
		repeat (9) send_tick();
		program_timing(16'd4, 16'd1, 16'd6, 16'd3, 1'b0);
		finish_frame();
	endtask

	// A write to an unmapped index must leave the timing alone
	task automatic test_unmapped_index();
		program_timing(16'd4, 16'd1, 16'd6, 16'd3, 1'b1);
		run_frame(8'h3C, 0);
	endtask

	// Largest register values in the bit time a byte does not use; no idling at all
	task automatic test_extremes();
		tx_calm = 1'b1;
		rx_calm = 1'b1;
		program_timing(16'd2, 16'd1, TICK_MAX, 16'd2, 1'b0);
		run_frame(8'h00, 1);
		program_timing(16'd1, TICK_MAX, 16'd2, 16'd1, 1'b0);
		run_frame(8'hFF, 0);
		tx_calm = 1'b0;
		rx_calm = 1'b0;
	endtask

	// Receiver holds off while ticks keep coming, so the input stalls
	task automatic test_backpressure();
		program_timing(16'd1, 16'd1, 16'd2, 16'd1, 1'b0);
		send_item(CMD_SEND, 8'h96);
		tx_calm = 1'b1;
		hold_requests++;
		repeat (40) send_tick();
		tx_calm = 1'b0;
		wait_drain();
	endtask

	// Well-formed frames with random bytes and timing, plus stray sends and idle ticks
	task automatic test_random();
		int start;
		start = frame_items;
		while (frame_items - start < RAND_ITEMS) begin
			program_timing(rand_tick(), rand_tick(), rand_tick(), rand_tick(),
				$urandom_range(3) == 0);
			repeat ($urandom_range(60, 30)) begin
				if (lp_phase == ST_IDLE) begin
					if ($urandom_range(99) < 85)
						send_item(CMD_SEND, 8'($urandom));
					else
						send_tick();
				end else if ($urandom_range(99) < 6) begin
					send_item(CMD_SEND, 8'($urandom));
				end else begin
					send_tick();
				end
			end
		end
	endtask

	initial begin
		repeat (RST_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		test_idle_and_defaults();
		test_min_timing();
		test_mid_frame_change();
		test_unmapped_index();
		test_extremes();
		test_backpressure();
		test_random();
		wait_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && line_results.size() == 0)
			$display("pulse_width_serial_transmitter: match");
		else
			$display("pulse_width_serial_transmitter: mismatch");
		$finish;
	end

	// Run limit
	initial begin
		#(LIMIT_CYCLES * 2 * CLK_HALF);
		$display("pulse_width_serial_transmitter: mismatch");
		$finish;
	end

endmodule

>>> filelist.f
src/pwst_pkg.sv
src/pwst_core.sv
src/pulse_width_serial_transmitter.sv
dv/pulse_width_serial_transmitter_test.sv
